>>> sv/usdm_pkg.sv
`default_nettype none
package usdm_pkg;

   localparam logic [11:0] OFF_SEL    = 12'hFF8;
   localparam logic [11:0] OFF_STAT   = 12'h014;
   localparam logic [11:0] OFF_U_CTRL = 12'h018;
   localparam logic [11:0] OFF_U_DATA = 12'h01C;
   localparam logic [11:0] OFF_U_FIFO = 12'h028;
   localparam logic [11:0] OFF_S_CR   = 12'h010;
   localparam logic [11:0] OFF_S_TCR  = 12'h060;
   localparam logic [11:0] OFF_S_TDR  = 12'h064;
   localparam logic [11:0] OFF_S_RDR  = 12'h074;

   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   localparam logic [2:0] SEL_UART     = 3'd1;
   localparam logic [2:0] SEL_UART_ALT = 3'd7;
   localparam logic [2:0] SEL_SPI      = 3'd2;
   localparam int         SEL_LOCK     = 3;

   localparam logic       MODE_WRITE = 1'b1;

   // UART control and status bits
   localparam int U_TE   = 19;
   localparam int U_RIE  = 21;
   localparam int U_TCIE = 22;
   localparam int U_TIE  = 23;
   localparam int U_IDLE = 20;
   localparam int U_RDRF = 21;
   localparam int U_TC   = 22;
   localparam int U_TDRE = 23;
   localparam logic [31:0] U_W1C_MASK = 32'hC01F_C000;
   localparam int F_RXEMPT = 22;
   localparam int F_TXEMPT = 23;

   // SPI control and status bits
   localparam int S_MEN   = 0;
   localparam int S_RRF   = 9;
   localparam int S_TDF   = 0;
   localparam int S_RDF   = 1;
   localparam int S_TCF   = 10;
   localparam int S_TXMSK = 18;
   localparam int S_RXMSK = 19;
   localparam int S_CONT  = 21;

   localparam logic [7:0] SPI_IDLE_BYTE = 8'hFF;

   typedef struct packed {
      logic        mode;
      logic [11:0] offset;
      logic [2:0]  access_size;
      logic [31:0] write_data;
      logic        peek;
      logic        uart_rx_ready;
      logic [7:0]  uart_rx_byte;
      logic [7:0]  spi_in_byte;
   } usdm_req_type;

   typedef struct packed {
      logic        handled;
      logic [31:0] read_data;
      logic        irq_raise;
      logic        uart_tx_valid;
      logic [7:0]  uart_tx_byte;
      logic        uart_rx_pop;
      logic        spi_xfer_valid;
      logic [7:0]  spi_tx_byte;
      logic        spi_end;
   } usdm_rsp_type;

   typedef struct packed {
      logic [3:0]  select_nibble;
      logic [31:0] uart_control;
      logic [31:0] uart_status;
      logic [31:0] uart_fifo_status;
      logic [31:0] spi_control;
      logic [31:0] spi_status;
      logic [31:0] spi_transfer_command;
      logic [7:0]  spi_rx_hold;
      logic        spi_rx_full;
   } usdm_state_type;

endpackage
`default_nettype wire

>>> sv/usdm_core.sv
`default_nettype none
module usdm_core (
   input  usdm_pkg::usdm_req_type   req,
   input  usdm_pkg::usdm_state_type cur,
   output usdm_pkg::usdm_state_type nxt,
   output usdm_pkg::usdm_rsp_type   rsp
);
   import usdm_pkg::*;

   logic        fn_uart;
   logic        fn_spi;
   logic        handled;
   logic        is_word;
   logic [31:0] size_mask;
   logic [31:0] masked_val;
   logic [7:0]  got;

   assign fn_uart = (cur.select_nibble[2:0] == SEL_UART) ||
                    (cur.select_nibble[2:0] == SEL_UART_ALT);
   assign fn_spi  = (cur.select_nibble[2:0] == SEL_SPI);
   assign is_word = (req.access_size == SIZE_WORD);

   always_comb begin
      unique case (req.access_size)
         SIZE_BYTE: size_mask = 32'h0000_00FF;
         SIZE_HALF: size_mask = 32'h0000_FFFF;
         default:   size_mask = 32'hFFFF_FFFF;
      endcase
   end

   assign masked_val = req.write_data & size_mask;

   always_comb begin
      logic        refresh;
      logic        refresh_ready;
      logic        want_irq;
      logic [31:0] tracked;

      nxt           = cur;
      rsp           = '0;
      handled       = 1'b0;
      refresh       = 1'b0;
      refresh_ready = req.uart_rx_ready;
      want_irq      = 1'b0;
      got           = SPI_IDLE_BYTE;
      tracked       = '0;

      if (req.mode == MODE_WRITE) begin
         if (req.offset == OFF_SEL) begin
            if (!cur.select_nibble[SEL_LOCK]) nxt.select_nibble = req.write_data[3:0];
            handled = 1'b1;
         end else if (fn_uart) begin
            if (req.offset == OFF_U_DATA) begin
               rsp.uart_tx_valid = cur.uart_control[U_TE];
               rsp.uart_tx_byte  = cur.uart_control[U_TE] ? req.write_data[7:0] : 8'h00;
               refresh  = 1'b1;
               want_irq = 1'b1;
               handled  = 1'b1;
            end else if (req.offset == OFF_STAT) begin
               nxt.uart_status = cur.uart_status & ~(req.write_data & U_W1C_MASK);
               refresh = 1'b1;
               handled = 1'b1;
            end else if (req.offset == OFF_U_CTRL && is_word) begin
               nxt.uart_control = req.write_data;
               refresh  = 1'b1;
               want_irq = 1'b1;
               handled  = 1'b1;
            end
         end else if (fn_spi && is_word) begin
            if (req.offset == OFF_S_CR) begin
               nxt.spi_control        = req.write_data;
               nxt.spi_control[S_RRF] = 1'b0;
               if (req.write_data[S_RRF]) nxt.spi_rx_full = 1'b0;
               rsp.spi_end = !req.write_data[S_MEN];
               handled = 1'b1;
            end else if (req.offset == OFF_S_TDR) begin
               if (cur.spi_control[S_MEN]) begin
                  if (!cur.spi_transfer_command[S_TXMSK]) begin
                     rsp.spi_xfer_valid = 1'b1;
                     rsp.spi_tx_byte    = req.write_data[7:0];
                     got                = req.spi_in_byte;
                  end
                  if (!cur.spi_transfer_command[S_RXMSK]) begin
                     nxt.spi_rx_hold = got;
                     nxt.spi_rx_full = 1'b1;
                  end
                  nxt.spi_status[S_TCF] = 1'b1;
                  rsp.spi_end = !cur.spi_transfer_command[S_CONT];
               end
               handled = 1'b1;
            end else if (req.offset == OFF_STAT) begin
               nxt.spi_status = cur.spi_status & ~req.write_data;
               handled = 1'b1;
            end
         end
         // plain store into the tracked register
         if (!handled) begin
            priority if (req.offset == OFF_S_CR) begin
               nxt.spi_control = masked_val;
            end else if (req.offset == OFF_STAT) begin
               if (fn_spi) nxt.spi_status = masked_val;
               else        nxt.uart_status = masked_val;
            end else if (req.offset == OFF_U_CTRL) begin
               nxt.uart_control = masked_val;
            end else if (req.offset == OFF_U_FIFO) begin
               nxt.uart_fifo_status = masked_val;
            end else if (req.offset == OFF_S_TCR) begin
               nxt.spi_transfer_command = masked_val;
            end else begin
               nxt.select_nibble = nxt.select_nibble;
            end
         end
      end else begin
         if (fn_uart) begin
            if (req.offset == OFF_U_DATA) begin
               rsp.read_data = req.uart_rx_ready ? {24'h0, req.uart_rx_byte} : 32'h0;
               if (!req.peek) begin
                  rsp.uart_rx_pop = req.uart_rx_ready;
                  refresh         = 1'b1;
                  refresh_ready   = 1'b0;
               end
               handled = 1'b1;
            end else if (req.offset == OFF_STAT || req.offset == OFF_U_FIFO) begin
               refresh = 1'b1;
            end
         end else if (fn_spi && is_word) begin
            if (req.offset == OFF_S_RDR) begin
               rsp.read_data = cur.spi_rx_full ? {24'h0, cur.spi_rx_hold} : 32'h0;
               if (!req.peek) begin
                  nxt.spi_rx_full       = 1'b0;
                  nxt.spi_status[S_RDF] = 1'b0;
               end
               handled = 1'b1;
            end else if (req.offset == OFF_STAT) begin
               rsp.read_data        = cur.spi_status;
               rsp.read_data[S_TDF] = 1'b1;
               if (cur.spi_rx_full) rsp.read_data[S_RDF] = 1'b1;
               handled = 1'b1;
            end
         end
      end

      if (refresh) begin
         nxt.uart_status[U_TDRE]      = 1'b1;
         nxt.uart_status[U_TC]        = 1'b1;
         nxt.uart_fifo_status[F_TXEMPT] = 1'b1;
         nxt.uart_status[U_RDRF]      = refresh_ready;
         nxt.uart_fifo_status[F_RXEMPT] = !refresh_ready;
         if (!refresh_ready) nxt.uart_status[U_IDLE] = 1'b1;
      end

      if (want_irq) begin
         rsp.irq_raise = (nxt.uart_control[U_RIE]  && nxt.uart_status[U_RDRF]) ||
                         (nxt.uart_control[U_TIE]  && nxt.uart_status[U_TDRE]) ||
                         (nxt.uart_control[U_TCIE] && nxt.uart_status[U_TC]);
      end

      // plain read sees the register after any refresh
      if (req.mode != MODE_WRITE && !handled) begin
         priority if (req.offset == OFF_SEL) begin
            tracked = {28'h0, nxt.select_nibble};
         end else if (req.offset == OFF_S_CR) begin
            tracked = nxt.spi_control;
         end else if (req.offset == OFF_STAT) begin
            tracked = fn_spi ? nxt.spi_status : nxt.uart_status;
         end else if (req.offset == OFF_U_CTRL) begin
            tracked = nxt.uart_control;
         end else if (req.offset == OFF_U_FIFO) begin
            tracked = nxt.uart_fifo_status;
         end else if (req.offset == OFF_S_TCR) begin
            tracked = nxt.spi_transfer_command;
         end else begin
            tracked = '0;
         end
         rsp.read_data = tracked & size_mask;
      end

      rsp.handled = handled;
   end

endmodule
`default_nettype wire

>>> sv/uart_spi_dual_mode_register_unit.sv
`default_nettype none
// Register unit for a communication slot that works as a UART or as an SPI master.
// Request channel (req_*): one bus access per request, with the UART receive
// status and byte and the byte the SPI bus returns for a transfer.
// Response channel (rsp_*): one response per request, in order, carrying the
// read data, the handled flag and the UART and SPI side signals.
// A request is taken when req_valid is high and req_stall is low; a response
// is taken when rsp_valid is high and rsp_stall is low.
// A request passes through the input register, then the decode and register
// update into the response register.
// Throughput: one request per cycle while the response is not stalled; the state
// update is a single pass of decode and masking logic between the two registers.
// Reset clears the function select, all UART and SPI registers and both
// pipeline valids; the unit takes a request in the first cycle after reset.
// When the receiver stalls, the response holds, the request in the input
// register waits, and req_stall rises once both registers are occupied.
module uart_spi_dual_mode_register_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_mode,
   input  wire logic [11:0] req_offset,
   input  wire logic [2:0]  req_access_size,
   input  wire logic [31:0] req_write_data,
   input  wire logic        req_peek,
   input  wire logic        req_uart_rx_ready,
   input  wire logic [7:0]  req_uart_rx_byte,
   input  wire logic [7:0]  req_spi_in_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_handled,
   output      logic [31:0] rsp_read_data,
   output      logic        rsp_irq_raise,
   output      logic        rsp_uart_tx_valid,
   output      logic [7:0]  rsp_uart_tx_byte,
   output      logic        rsp_uart_rx_pop,
   output      logic        rsp_spi_xfer_valid,
   output      logic [7:0]  rsp_spi_tx_byte,
   output      logic        rsp_spi_end
);
   import usdm_pkg::*;

   logic           in_valid_ff, in_valid_in;
   usdm_req_type   in_req_ff;
   logic           out_valid_ff, out_valid_in;
   usdm_rsp_type   out_rsp_ff;
   usdm_state_type state_ff, state_in;
   usdm_rsp_type   core_rsp;
   logic           advance;
   logic           take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   usdm_core u_core (
      .req (in_req_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // commit register updates only when the request moves on
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff.mode          <= req_mode;
         in_req_ff.offset        <= req_offset;
         in_req_ff.access_size   <= req_access_size;
         in_req_ff.write_data    <= req_write_data;
         in_req_ff.peek          <= req_peek;
         in_req_ff.uart_rx_ready <= req_uart_rx_ready;
         in_req_ff.uart_rx_byte  <= req_uart_rx_byte;
         in_req_ff.spi_in_byte   <= req_spi_in_byte;
      end
      if (advance) out_rsp_ff <= core_rsp;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_handled        = out_rsp_ff.handled;
   assign rsp_read_data      = out_rsp_ff.read_data;
   assign rsp_irq_raise      = out_rsp_ff.irq_raise;
   assign rsp_uart_tx_valid  = out_rsp_ff.uart_tx_valid;
   assign rsp_uart_tx_byte   = out_rsp_ff.uart_tx_byte;
   assign rsp_uart_rx_pop    = out_rsp_ff.uart_rx_pop;
   assign rsp_spi_xfer_valid = out_rsp_ff.spi_xfer_valid;
   assign rsp_spi_tx_byte    = out_rsp_ff.spi_tx_byte;
   assign rsp_spi_end        = out_rsp_ff.spi_end;

endmodule
`default_nettype wire

>>> sv/usdm_checker.sv
`default_nettype none
module usdm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_handled,
   input wire logic [31:0] rsp_read_data,
   input wire logic        rsp_irq_raise,
   input wire logic        rsp_uart_tx_valid,
   input wire logic        rsp_uart_rx_pop,
   input wire logic        rsp_spi_xfer_valid,
   input wire logic        rsp_spi_end
);

   // nothing can be in flight right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled response changed");

   // response side signals only come from handled accesses
   a_side_handled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handled |-> !rsp_irq_raise && !rsp_uart_tx_valid &&
         !rsp_uart_rx_pop && !rsp_spi_xfer_valid && !rsp_spi_end)
      else $error("side effect on unhandled access");

   // transmits are writes and return no data
   a_tx_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_uart_tx_valid || rsp_spi_xfer_valid) |-> rsp_read_data == 32'h0)
      else $error("transmit response carries read data");

   a_pop_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_uart_rx_pop |-> rsp_read_data[31:8] == 24'h0 && !rsp_irq_raise)
      else $error("receive pop with malformed response");

endmodule

bind uart_spi_dual_mode_register_unit usdm_checker u_usdm_checker (.*);
`default_nettype wire
